// ===== rtl/core/mma_pkg.sv =====
// Shared constants and types of the multichannel moving average block.
package mma_pkg;

  localparam int DATA_W         = 16;
  localparam int NUM_LANES      = 9;
  localparam int LEN_W          = 5;
  localparam int WINDOW_MAX_DEF = 16;

  localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(5);

  // Per-item control that the sequencer hands to every lane.
  typedef struct packed {
    logic clear;       // drop the running sum after a window length write
    logic accept;      // a new word is taken: write history, read leaving sample
    logic update;      // fold the new and the leaving sample into the sum, start divide
    logic drop_valid;  // leaving sample was written since the last clear
  } lane_ctrl_t;

endpackage

// ===== rtl/core/mma_in_if.sv =====
// Input channel carrying one nine-axis sample set per word.
interface mma_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mma_pkg::DATA_W-1:0] acc_x;
  logic signed [mma_pkg::DATA_W-1:0] acc_y;
  logic signed [mma_pkg::DATA_W-1:0] acc_z;
  logic signed [mma_pkg::DATA_W-1:0] gyro_x;
  logic signed [mma_pkg::DATA_W-1:0] gyro_y;
  logic signed [mma_pkg::DATA_W-1:0] gyro_z;
  logic signed [mma_pkg::DATA_W-1:0] mag_x;
  logic signed [mma_pkg::DATA_W-1:0] mag_y;
  logic signed [mma_pkg::DATA_W-1:0] mag_z;

  modport source (
    output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
    input  ready
  );
  modport sink (
    input  valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
    output ready
  );
endinterface

// ===== rtl/core/mma_out_if.sv =====
// Result channel carrying the nine window means per word.
interface mma_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mma_pkg::DATA_W-1:0] acc_x_mean;
  logic signed [mma_pkg::DATA_W-1:0] acc_y_mean;
  logic signed [mma_pkg::DATA_W-1:0] acc_z_mean;
  logic signed [mma_pkg::DATA_W-1:0] gyro_x_mean;
  logic signed [mma_pkg::DATA_W-1:0] gyro_y_mean;
  logic signed [mma_pkg::DATA_W-1:0] gyro_z_mean;
  logic signed [mma_pkg::DATA_W-1:0] mag_x_mean;
  logic signed [mma_pkg::DATA_W-1:0] mag_y_mean;
  logic signed [mma_pkg::DATA_W-1:0] mag_z_mean;

  modport source (
    output valid, acc_x_mean, acc_y_mean, acc_z_mean, gyro_x_mean, gyro_y_mean,
           gyro_z_mean, mag_x_mean, mag_y_mean, mag_z_mean,
    input  ready
  );
  modport sink (
    input  valid, acc_x_mean, acc_y_mean, acc_z_mean, gyro_x_mean, gyro_y_mean,
           gyro_z_mean, mag_x_mean, mag_y_mean, mag_z_mean,
    output ready
  );
endinterface

// ===== rtl/core/mma_div.sv =====
// Radix-2 restoring divider of a signed sum by a small unsigned window length.
module mma_div #(
  parameter int DIVIDEND_W = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [DIVIDEND_W-1:0]  dividend,
  input  logic [mma_pkg::LEN_W-1:0]     divisor,
  output logic signed [DIVIDEND_W-1:0]  quotient,
  output logic                          done
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);
  localparam int LW    = mma_pkg::LEN_W;

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  neg_r;
  logic [LW-1:0]         div_r;
  logic [LW-1:0]         rem_r;
  logic [LW-1:0]         rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVIDEND_W-1:0] mag;
  logic [LW:0]           trial;
  logic [LW:0]           diff;
  logic                  fits;

  // Magnitude of the most negative sum wraps to the right unsigned value.
  assign mag   = dividend[DIVIDEND_W-1] ? (DIVIDEND_W'(0) - dividend) : dividend;
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    if (fits) begin
      rem_nxt = diff[LW-1:0];
    end else begin
      rem_nxt = trial[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[DIVIDEND_W-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  // Truncation toward zero: divide magnitudes, then restore the sign.
  assign quotient = neg_r ? signed'(DIVIDEND_W'(0) - quo_r) : signed'(quo_r);
  assign done     = done_r;

endmodule

// ===== rtl/core/mma_lane.sv =====
// One channel of the filter: sample history, running sum and divider.
module mma_lane #(
  parameter int WINDOW_MAX = mma_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mma_pkg::lane_ctrl_t                ctrl,
  input  logic [$clog2(WINDOW_MAX)-1:0]      wr_addr,
  input  logic [$clog2(WINDOW_MAX)-1:0]      rd_addr,
  input  logic signed [mma_pkg::DATA_W-1:0]  sample_in,
  input  logic [mma_pkg::LEN_W-1:0]          divisor,
  output logic signed [mma_pkg::DATA_W-1:0]  mean,
  output logic                               done
);

  localparam int DW    = mma_pkg::DATA_W;
  localparam int SUM_W = DW + $clog2(WINDOW_MAX);

  logic signed [DW-1:0]    hist_mem [WINDOW_MAX];
  logic signed [DW-1:0]    rd_data_r;
  logic signed [DW-1:0]    sample_r;
  logic signed [DW-1:0]    leaving;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] quotient;

  // Read happens before the write, so a full window sees the overwritten sample.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      hist_mem[wr_addr] <= sample_in;
      rd_data_r         <= hist_mem[rd_addr];
      sample_r          <= sample_in;
    end
  end

  assign leaving = ctrl.drop_valid ? rd_data_r : '0;
  assign sum_nxt = sum_r + SUM_W'(sample_r) - SUM_W'(leaving);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.clear) begin
      sum_r <= '0;
    end else if (ctrl.update) begin
      sum_r <= sum_nxt;
    end
  end

  mma_div #(
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.update),
    .dividend (sum_nxt),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (done)
  );

  assign mean = signed'(quotient[DW-1:0]);

endmodule

// ===== rtl/core/multichannel_moving_average_top.sv =====
// Top level of the nine-channel boxcar moving average filter.
//
//   Channel   Direction  Handshake              Word
//   in_ch     in         valid/ready            nine signed 16-bit samples
//   out_ch    out        valid/ready            nine signed 16-bit window means
//   cfg       in         cfg_wr_en, no ready    5-bit window length
//
// One word passes through the accept, the sum update and a bit-serial divide
// over every bit of the sum, then the load of the result register; a new word
// is taken only once the previous one has left the lanes.
// The serial divider in each lane bounds the word rate; all nine lanes run at once.
// Reset is synchronous; it restores a window length of 5 and an empty history.
// A finished result waits in the output register while the next word is taken;
// a stalled output only holds the lanes once their next result is ready.
module multichannel_moving_average_top #(
  parameter int WINDOW_MAX = mma_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mma_in_if.sink                        in_ch,
  mma_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [mma_pkg::LEN_W-1:0]     cfg_wr_data
);

  localparam int DW     = mma_pkg::DATA_W;
  localparam int LANES  = mma_pkg::NUM_LANES;
  localparam int LW     = mma_pkg::LEN_W;
  localparam int IDX_W  = $clog2(WINDOW_MAX);
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int D_W    = IDX_W + LW + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SUM  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [LW-1:0]       wlen_r;
  logic [LW-1:0]       eff_len;
  logic [IDX_W-1:0]    pos_r;
  logic [FILL_W-1:0]   fill_r;
  logic [IDX_W-1:0]    drop_addr;
  logic [D_W-1:0]      drop_diff;
  logic                drop_valid_r;
  logic                accept;
  logic                done_all;
  logic                load_out;
  logic                out_valid_r;
  logic [LANES-1:0]    lane_done;
  mma_pkg::lane_ctrl_t lane_ctrl;

  logic signed [DW-1:0] samples [LANES];
  logic signed [DW-1:0] means   [LANES];
  logic signed [DW-1:0] mean_r  [LANES];

  // The sequencer takes a new word only between items; the user must make configuration
  // writes only while idle, and the block itself does not enforce it.
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign done_all    = &lane_done;
  assign load_out    = (state_r == S_DIV) && done_all && (!out_valid_r || out_ch.ready);

  // Zero counts as a window of one; lengths beyond the history saturate.
  always_comb begin
    if (wlen_r == '0) begin
      eff_len = LW'(1);
    end else if (int'(wlen_r) > WINDOW_MAX) begin
      eff_len = LW'(WINDOW_MAX);
    end else begin
      eff_len = wlen_r;
    end
  end

  // The sample leaving the window sits eff_len slots behind the write pointer.
  always_comb begin
    drop_diff = D_W'(pos_r) - D_W'(eff_len);
    if (drop_diff[D_W-1]) begin
      drop_diff = drop_diff + D_W'(WINDOW_MAX);
    end
    drop_addr = drop_diff[IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wlen_r       <= mma_pkg::RESET_LENGTH;
      pos_r        <= '0;
      fill_r       <= '0;
      drop_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        // A new window length starts over with an empty history.
        wlen_r <= cfg_wr_data;
        pos_r  <= '0;
        fill_r <= '0;
      end else if (accept) begin
        // Entries below the fill count were written since the last clear.
        drop_valid_r <= (FILL_W'(drop_addr) < fill_r);
        if (int'(pos_r) == WINDOW_MAX - 1) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
        if (int'(fill_r) < WINDOW_MAX) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign lane_ctrl.clear      = cfg_wr_en;
  assign lane_ctrl.accept     = accept;
  assign lane_ctrl.update     = (state_r == S_SUM);
  assign lane_ctrl.drop_valid = drop_valid_r;

  assign samples[0] = in_ch.acc_x;
  assign samples[1] = in_ch.acc_y;
  assign samples[2] = in_ch.acc_z;
  assign samples[3] = in_ch.gyro_x;
  assign samples[4] = in_ch.gyro_y;
  assign samples[5] = in_ch.gyro_z;
  assign samples[6] = in_ch.mag_x;
  assign samples[7] = in_ch.mag_y;
  assign samples[8] = in_ch.mag_z;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mma_lane #(
      .WINDOW_MAX (WINDOW_MAX)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (lane_ctrl),
      .wr_addr   (pos_r),
      .rd_addr   (drop_addr),
      .sample_in (samples[g]),
      .divisor   (eff_len),
      .mean      (means[g]),
      .done      (lane_done[g])
    );
  end

  // Merge stage: the nine lane means are gathered into one result word.
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < LANES; i++) begin
        mean_r[i] <= means[i];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.acc_x_mean  = mean_r[0];
  assign out_ch.acc_y_mean  = mean_r[1];
  assign out_ch.acc_z_mean  = mean_r[2];
  assign out_ch.gyro_x_mean = mean_r[3];
  assign out_ch.gyro_y_mean = mean_r[4];
  assign out_ch.gyro_z_mean = mean_r[5];
  assign out_ch.mag_x_mean  = mean_r[6];
  assign out_ch.mag_y_mean  = mean_r[7];
  assign out_ch.mag_z_mean  = mean_r[8];

`ifndef SYNTH
  // The fill count never runs past the history depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= WINDOW_MAX)
    else $error("fill count exceeds history depth");

  // A new result appears only once every lane has finished dividing.
  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done_all))
    else $error("result raised before the dividers finished");

  // No word is taken while the lanes are dividing.
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !in_ch.ready)
    else $error("input ready while dividing");

  // A window length write empties the history.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (fill_r == '0) && (pos_r == '0))
    else $error("window length write did not clear the history");
`endif

endmodule

// ===== bench/multichannel_moving_average_top_tb.sv =====
// Self-checking testbench of the nine-channel boxcar moving average filter.
`timescale 1ns / 100ps

module multichannel_moving_average_top_tb;

  localparam int               NUM_LANES    = mma_pkg::NUM_LANES;
  localparam int               DATA_W       = mma_pkg::DATA_W;
  localparam int               LEN_W        = mma_pkg::LEN_W;
  localparam logic [LEN_W-1:0] RESET_LENGTH = mma_pkg::RESET_LENGTH;

  // The block is built with its default history depth, so the bench uses the same figure.
  localparam int TB_WMAX       = mma_pkg::WINDOW_MAX_DEF;
  localparam int RANDOM_ITEMS  = 1950;
  // Settle well past the time that one word spends inside the block.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 80;
  localparam int LONG_HOLD     = 400;
  localparam int REPORT_LIMIT  = 10;

  // Lane 0 is acc_x, lane 8 is mag_z, in the order of the channel fields.
  typedef logic [NUM_LANES-1:0][DATA_W-1:0] lane_vec_t;

  // One row of the directed table: an optional window length write before the word,
  // the word itself and, where it is obvious, the means typed in by hand.
  typedef struct packed {
    logic             wr_cfg;
    logic [LEN_W-1:0] cfg_val;
    lane_vec_t        samples;
    logic             typed;
    lane_vec_t        means;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  mma_in_if  in_if ();
  mma_out_if out_if ();

  multichannel_moving_average_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the filter state: window length register, per-lane delay lines,
  // running sums and the circular write pointer.
  logic [LEN_W-1:0]    win_len_reg;
  logic signed [15:0]  hist_taps [NUM_LANES][TB_WMAX];
  logic signed [19:0]  lane_sums [NUM_LANES];
  int                  tap_ptr;

  // Means still owed by the block, oldest first.
  lane_vec_t           pending_means [$];
  stim_row_t           directed [$];

  int  fail_count;
  int  results_checked;
  int  directed_sent;
  int  random_sent;
  int  cfg_writes;
  int  burst_left;
  int  longest_in_stall;
  bit  want_long_hold;
  int  long_holds;

  lane_vec_t got_means;
  lane_vec_t want_means;
  logic [NUM_LANES-1:0] bad_lanes;

  function automatic lane_vec_t lanes(input int a0, input int a1, input int a2,
                                      input int a3, input int a4, input int a5,
                                      input int a6, input int a7, input int a8);
    lane_vec_t v;
    v[0] = DATA_W'(a0);
    v[1] = DATA_W'(a1);
    v[2] = DATA_W'(a2);
    v[3] = DATA_W'(a3);
    v[4] = DATA_W'(a4);
    v[5] = DATA_W'(a5);
    v[6] = DATA_W'(a6);
    v[7] = DATA_W'(a7);
    v[8] = DATA_W'(a8);
    return v;
  endfunction

  function automatic stim_row_t make_row(input logic wr, input int val, input lane_vec_t s,
                                         input logic t, input lane_vec_t m);
    stim_row_t r;
    r.wr_cfg  = wr;
    r.cfg_val = LEN_W'(val);
    r.samples = s;
    r.typed   = t;
    r.means   = m;
    return r;
  endfunction

  // Style 0 pins each lane near one extreme so that full windows reach the sum limits;
  // style 1 mixes extremes, tiny values and full-range noise.
  function automatic lane_vec_t random_samples(input int style);
    lane_vec_t v;
    for (int lane = 0; lane < NUM_LANES; lane++) begin
      if (style == 0) begin
        if ($urandom_range(0, 19) == 0) begin
          v[lane] = DATA_W'($urandom());
        end else begin
          v[lane] = (lane % 2 == 0) ? 16'h7fff : 16'h8000;
        end
      end else begin
        case ($urandom_range(0, 7))
          0: v[lane] = 16'h7fff;
          1: v[lane] = 16'h8000;
          2: v[lane] = DATA_W'($urandom_range(0, 16) - 8);
          default: v[lane] = DATA_W'($urandom());
        endcase
      end
    end
    return v;
  endfunction

  // Clearing the history happens at reset and on every window length write.
  task automatic clear_history();
    for (int lane = 0; lane < NUM_LANES; lane++) begin
      lane_sums[lane] = '0;
      for (int k = 0; k < TB_WMAX; k++) begin
        hist_taps[lane][k] = '0;
      end
    end
    tap_ptr = 0;
  endtask

  // Advance the shadow filter by one word and return the nine means it yields.
  // A zero length acts as one and lengths past the history depth are clipped to it.
  task automatic window_mean_step(input lane_vec_t smp, output lane_vec_t mean_out);
    int n;
    int leaving_idx;
    int s;
    int q;
    n = int'(win_len_reg);
    if (n < 1) begin
      n = 1;
    end
    if (n > TB_WMAX) begin
      n = TB_WMAX;
    end
    leaving_idx = (tap_ptr + TB_WMAX - n) % TB_WMAX;
    for (int lane = 0; lane < NUM_LANES; lane++) begin
      s = $signed(smp[lane]);
      lane_sums[lane] = lane_sums[lane] + s - int'(hist_taps[lane][leaving_idx]);
      hist_taps[lane][tap_ptr] = smp[lane];
      // Signed integer division truncates toward zero, as the block must.
      q = int'(lane_sums[lane]) / n;
      mean_out[lane] = q[DATA_W-1:0];
    end
    tap_ptr = (tap_ptr + 1) % TB_WMAX;
  endtask

  // Offer one word on the input channel. Called at a falling edge, returns at one.
  // Words go out in bursts; between bursts valid may drop for a random gap.
  task automatic send_word(input lane_vec_t smp, input logic typed, input lane_vec_t typed_means);
    lane_vec_t predicted;
    int gap;
    int stall;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(4, 25);
        default: gap = $urandom_range(26, 60);
      endcase
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid  <= 1'b1;
    in_if.acc_x  <= smp[0];
    in_if.acc_y  <= smp[1];
    in_if.acc_z  <= smp[2];
    in_if.gyro_x <= smp[3];
    in_if.gyro_y <= smp[4];
    in_if.gyro_z <= smp[5];
    in_if.mag_x  <= smp[6];
    in_if.mag_y  <= smp[7];
    in_if.mag_z  <= smp[8];
    stall = 0;
    @(posedge clk);
    while (!in_if.ready) begin
      stall++;
      @(posedge clk);
    end
    if (stall > longest_in_stall) begin
      longest_in_stall = stall;
    end
    window_mean_step(smp, predicted);
    pending_means.push_back(typed ? typed_means : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // Write the window length. The block has to be idle: every owed result is out and
  // the last word has had time to leave the lanes.
  task automatic program_window(input int len);
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_means.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LEN_W'(len);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_len_reg = LEN_W'(len);
    clear_history();
    cfg_writes++;
    burst_left = 0;
  endtask

  task automatic note_mismatch(input string what, input lane_vec_t want, input lane_vec_t got,
                               input logic [NUM_LANES-1:0] mask);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s, lanes %b (mag_z..acc_x): expected %h, got %h",
               $time, what, mask, want, got);
    end
  endtask

  // Result checker: every word taken from the output is compared lane by lane
  // with the oldest owed set of means.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_means[0] = out_if.acc_x_mean;
      got_means[1] = out_if.acc_y_mean;
      got_means[2] = out_if.acc_z_mean;
      got_means[3] = out_if.gyro_x_mean;
      got_means[4] = out_if.gyro_y_mean;
      got_means[5] = out_if.gyro_z_mean;
      got_means[6] = out_if.mag_x_mean;
      got_means[7] = out_if.mag_y_mean;
      got_means[8] = out_if.mag_z_mean;
      results_checked++;
      if (pending_means.size() == 0) begin
        note_mismatch("result word with nothing owed", '0, got_means, '1);
      end else begin
        want_means = pending_means.pop_front();
        for (int lane = 0; lane < NUM_LANES; lane++) begin
          bad_lanes[lane] = (got_means[lane] !== want_means[lane]);
        end
        if (bad_lanes != '0) begin
          note_mismatch("mean mismatch", want_means, got_means, bad_lanes);
        end
      end
    end
  end

  // Receiver: ready follows a pattern of its own, changing at falling edges.
  // Modes are always-ready runs, random stalls at a random rate, a regular
  // one-in-N stall, and solid stall stretches. On request it holds ready low for
  // one long hold of LONG_HOLD so the block fills up and pushes back on its input.
  initial begin : receiver
    int run_left;
    int rx_mode;
    int rx_pct;
    int rx_period;
    int rx_phase;
    int hold_cnt;
    logic r;
    run_left  = 0;
    rx_mode   = 0;
    rx_pct    = 50;
    rx_period = 4;
    rx_phase  = 0;
    hold_cnt  = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (want_long_hold) begin
        hold_cnt++;
        out_if.ready <= 1'b0;
        if (hold_cnt >= LONG_HOLD) begin
          want_long_hold = 1'b0;
          hold_cnt = 0;
          long_holds++;
        end
      end else begin
        if (run_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          rx_pct    = $urandom_range(10, 90);
          rx_period = $urandom_range(2, 9);
          rx_phase  = 0;
          run_left  = (rx_mode == 3) ? $urandom_range(1, 12) : $urandom_range(20, 300);
        end
        case (rx_mode)
          0: r = 1'b1;
          1: r = ($urandom_range(0, 99) < rx_pct);
          2: r = (rx_phase % rx_period) != 0;
          default: r = 1'b0;
        endcase
        rx_phase++;
        run_left--;
        out_if.ready <= r;
      end
    end
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("Timeout: %0d results still owed", pending_means.size());
    $display("multichannel_moving_average_top_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int len;
    int style;
    int count;
    stim_row_t row;

    // Every input is known from time zero.
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_if.valid  = 1'b0;
    in_if.acc_x  = '0;
    in_if.acc_y  = '0;
    in_if.acc_z  = '0;
    in_if.gyro_x = '0;
    in_if.gyro_y = '0;
    in_if.gyro_z = '0;
    in_if.mag_x  = '0;
    in_if.mag_y  = '0;
    in_if.mag_z  = '0;
    fail_count       = 0;
    results_checked  = 0;
    directed_sent    = 0;
    random_sent      = 0;
    cfg_writes       = 0;
    burst_left       = 0;
    longest_in_stall = 0;
    want_long_hold   = 1'b0;
    long_holds       = 0;
    win_len_reg      = RESET_LENGTH;
    clear_history();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Right after reset the window is 5 over a zeroed history,
    // so the first means are the samples over 5, truncated toward zero.
    directed.push_back(make_row(1'b0, 0,
      lanes(32767, -32768, 1, -1, 0, 32767, -32768, 5, -5), 1'b1,
      lanes(6553, -6553, 0, 0, 0, 6553, -6553, 1, -1)));
    // A few more words at length 5 so the oldest samples start leaving the window.
    directed.push_back(make_row(1'b0, 0,
      lanes(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
      1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(21845, -21846, 4660, -4661, 255, -256, 1000, -1000, 7), 1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(-1, 1, -2, 2, 32767, -32768, 12345, -12345, 0), 1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(30000, -30000, 3, -3, 17, -17, 32767, -32768, 99), 1'b0, '0));
    // Length 1: each mean is its own sample, the most negative one included.
    directed.push_back(make_row(1'b1, 1,
      lanes(-32768, 32767, 0, -1, 1, 12345, -12345, 21845, -21846), 1'b1,
      lanes(-32768, 32767, 0, -1, 1, 12345, -12345, 21845, -21846)));
    // Length zero behaves as one.
    directed.push_back(make_row(1'b1, 0,
      lanes(100, -100, 32767, -32768, 7, -7, 0, 1, -1), 1'b1,
      lanes(100, -100, 32767, -32768, 7, -7, 0, 1, -1)));
    directed.push_back(make_row(1'b0, 0,
      lanes(-1, 2, -3, 4, -5, 6, -7, 8, -9), 1'b1,
      lanes(-1, 2, -3, 4, -5, 6, -7, 8, -9)));
    // Length 31 is clipped to the history depth of 16.
    directed.push_back(make_row(1'b1, 31,
      lanes(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767), 1'b1,
      lanes(2047, -2048, 2047, -2048, 2047, -2048, 2047, -2048, 2047)));
    directed.push_back(make_row(1'b0, 0,
      lanes(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767), 1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(-5, 5, -15, 15, 31, -31, 0, 0, 1), 1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(8191, -8192, 16383, -16384, 1, 2, 3, 4, 5), 1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(-7, -7, -7, 7, 7, 7, 0, -32768, 32767), 1'b0, '0));
    // Full window length from a cleared store.
    directed.push_back(make_row(1'b1, 16,
      lanes(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
      1'b1, lanes(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048)));
    directed.push_back(make_row(1'b0, 0,
      lanes(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
      1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
      1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0, '0));
    // Length 2: odd negative sums show truncation toward zero, and two most
    // negative samples give the most negative mean.
    directed.push_back(make_row(1'b1, 2,
      lanes(32767, -32768, -1, 1, 3, -3, 0, 32767, -32768), 1'b1,
      lanes(16383, -16384, 0, 0, 1, -1, 0, 16383, -16384)));
    directed.push_back(make_row(1'b0, 0,
      lanes(32767, -32768, -1, 1, 3, -3, 0, 32767, -32768), 1'b1,
      lanes(32767, -32768, -1, 1, 3, -3, 0, 32767, -32768)));
    directed.push_back(make_row(1'b1, 3,
      lanes(-1, -2, -3, 3, 2, 1, -32768, 32767, 9), 1'b1,
      lanes(0, 0, -1, 1, 0, 0, -10922, 10922, 3)));
    directed.push_back(make_row(1'b0, 0,
      lanes(-2, -2, 5, -5, 100, -100, -32768, 32767, 9), 1'b0, '0));
    directed.push_back(make_row(1'b0, 0,
      lanes(4, 4, -4, 4, -4, 4, -32768, 32767, -9), 1'b0, '0));

    foreach (directed[i]) begin
      row = directed[i];
      if (row.wr_cfg) begin
        program_window(int'(row.cfg_val));
      end
      send_word(row.samples, row.typed, row.means);
      directed_sent++;
    end

    // Random part, in phases of one window length each. The first phases hit the
    // full length, the long receiver hold, one, zero and the clipped maximum.
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: len = TB_WMAX;
        1: len = $urandom_range(2, TB_WMAX - 1);
        2: len = 1;
        3: len = 0;
        4: len = 31;
        default: len = $urandom_range(0, 31);
      endcase
      style = (phase == 0 || $urandom_range(0, 4) == 0) ? 0 : 1;
      count = $urandom_range(60, 200);
      if (count > RANDOM_ITEMS - random_sent) begin
        count = RANDOM_ITEMS - random_sent;
      end
      program_window(len);
      if (phase == 1) begin
        want_long_hold = 1'b1;
      end
      repeat (count) begin
        send_word(random_samples(style), 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    while (pending_means.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random sample sets over %0d window length writes.",
             directed_sent, random_sent, cfg_writes);
    $display("Checked %0d result words; %0d long receiver holds, longest input stall %0d cycles.",
             results_checked, long_holds, longest_in_stall);
    if (pending_means.size() != 0) begin
      $display("%0d result words never arrived", pending_means.size());
    end
    if (fail_count == 0 && pending_means.size() == 0) begin
      $display("multichannel_moving_average_top_tb: PASS");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("multichannel_moving_average_top_tb: FAIL");
    end
    $finish;
  end

endmodule
